[rtl/lzw_pkg.sv]
// Shared types and constants of the 12-bit LZW compressor.
`default_nettype none
package lzw_pkg;

  localparam int unsigned CodeW = 12;
  localparam int unsigned SlotW = 13;
  localparam logic [CodeW:0] FirstFree = 13'd256;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } lzw_in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_last;
  } lzw_out_t;

  // One dictionary record: the pair it codes and the hash slot that points at it.
  typedef struct packed {
    logic [CodeW-1:0] prefix;
    logic [7:0]       byte_val;
    logic [SlotW-1:0] slot;
  } lzw_dict_t;

endpackage
`default_nettype wire

[rtl/lzw_fifo.sv]
// Small register queue used on both sides of the compressor engine.
`default_nettype none
module lzw_fifo #(
  parameter int unsigned WIDTH = 9,
  parameter int unsigned DEPTH = 2
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] wdata,
  output logic                  full,
  input  wire logic             pop,
  output logic [WIDTH-1:0]      rdata,
  output logic                  empty
);
  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PtrW-1:0]  wr_ptr;
  logic [PtrW-1:0]  rd_ptr;
  logic [CntW-1:0]  count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CntW'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PtrW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PtrW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + CntW'(do_push) - CntW'(do_pop);
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CntW'(DEPTH)) else $error("queue count overflow");
  a_full_holds: assert property (@(posedge clk) disable iff (rst)
    full && !pop |=> full) else $error("full dropped without a pop");
  a_empty_holds: assert property (@(posedge clk) disable iff (rst)
    empty && !push |=> empty) else $error("empty dropped without a push");

endmodule
`default_nettype wire

[rtl/lzw_engine.sv]
// LZW engine: hashed dictionary search, code insertion and byte packing.
`default_nettype none
module lzw_engine #(
  parameter int unsigned DICT_LIMIT = 4095
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  input  wire lzw_pkg::lzw_in_t in_data,
  output logic                 in_pop,
  input  wire logic            out_full,
  output logic                 out_push,
  output lzw_pkg::lzw_out_t    out_data
);
  localparam int unsigned CW = lzw_pkg::CodeW;
  localparam int unsigned SW = lzw_pkg::SlotW;

  typedef enum logic [2:0] {
    S_CLR, S_IDLE, S_HASH, S_RD, S_DICT, S_CMP, S_SEND
  } state_t;

  state_t             state;
  logic [SW-1:0]      clr_idx;
  logic [7:0]         byte_r;
  logic               last_r;
  logic               have_prefix;
  logic [CW-1:0]      cur_prefix;
  logic [CW:0]        next_free;
  logic               nib_pending;
  logic [3:0]         pend_nib;
  logic [SW-1:0]      slot;
  logic [CW-1:0]      slot_q;
  lzw_pkg::lzw_dict_t dict_q;
  logic [7:0]         obuf [4];
  logic [2:0]         ocnt;
  logic [1:0]         oidx;

  // Hash slots hold a code; the dictionary record of that code names its slot back.
  logic [CW-1:0]      slot_mem [2**SW];
  lzw_pkg::lzw_dict_t dict_mem [2**CW];

  logic               finish;
  logic               miss;
  logic               live;
  logic               key_eq;
  logic               ins;
  logic [CW-1:0]      new_prefix;
  logic [7:0]         nbuf [4];
  logic [2:0]         ncnt;
  logic               n_np;
  logic [3:0]         n_pn;

  assign live = (slot_q >= CW'(256)) && ({1'b0, slot_q} < next_free)
             && (dict_q.slot == slot);
  assign key_eq = (dict_q.prefix == cur_prefix) && (dict_q.byte_val == byte_r);
  assign ins = miss && (next_free < (CW+1)'(DICT_LIMIT));

  always_comb begin
    finish     = 1'b0;
    miss       = 1'b0;
    new_prefix = cur_prefix;
    if (state == S_HASH && !have_prefix) begin
      finish     = 1'b1;
      new_prefix = {4'd0, byte_r};
    end else if (state == S_CMP) begin
      if (live && key_eq) begin
        finish     = 1'b1;
        new_prefix = slot_q;
      end else if (!live) begin
        finish     = 1'b1;
        miss       = 1'b1;
        new_prefix = {4'd0, byte_r};
      end
    end
  end

  // Packs up to two codes and the closing nibble into at most four bytes.
  always_comb begin
    nbuf[0] = '0;
    nbuf[1] = '0;
    nbuf[2] = '0;
    nbuf[3] = '0;
    ncnt    = '0;
    n_np    = nib_pending;
    n_pn    = pend_nib;
    if (miss) begin
      if (n_np) begin
        nbuf[ncnt[1:0]] = {n_pn, cur_prefix[11:8]};
        nbuf[ncnt[1:0] + 2'd1] = cur_prefix[7:0];
        ncnt = ncnt + 3'd2;
        n_np = 1'b0;
      end else begin
        nbuf[ncnt[1:0]] = cur_prefix[11:4];
        ncnt = ncnt + 3'd1;
        n_pn = cur_prefix[3:0];
        n_np = 1'b1;
      end
    end
    if (last_r) begin
      if (n_np) begin
        nbuf[ncnt[1:0]] = {n_pn, new_prefix[11:8]};
        nbuf[ncnt[1:0] + 2'd1] = new_prefix[7:0];
        ncnt = ncnt + 3'd2;
        n_np = 1'b0;
      end else begin
        nbuf[ncnt[1:0]] = new_prefix[11:4];
        nbuf[ncnt[1:0] + 2'd1] = {new_prefix[3:0], 4'd0};
        ncnt = ncnt + 3'd2;
      end
    end
  end

  assign in_pop   = (state == S_IDLE) && in_valid;
  assign out_push = (state == S_SEND) && !out_full;
  assign out_data.out_byte = obuf[oidx];
  assign out_data.out_last = last_r && (({1'b0, oidx} + 3'd1) == ocnt);

  // After reset every hash slot is zeroed once, so an empty slot reads as a byte code.
  always_ff @(posedge clk) begin
    slot_q <= slot_mem[slot];
    if (state == S_CLR) begin
      slot_mem[clr_idx] <= '0;
    end else if (ins) begin
      slot_mem[slot] <= next_free[CW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    dict_q <= dict_mem[slot_q];
    if (ins) begin
      dict_mem[next_free[CW-1:0]] <= '{prefix: cur_prefix, byte_val: byte_r, slot: slot};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_CLR;
      clr_idx     <= '0;
      have_prefix <= 1'b0;
      cur_prefix  <= '0;
      next_free   <= lzw_pkg::FirstFree;
      nib_pending <= 1'b0;
      pend_nib    <= '0;
      ocnt        <= '0;
      oidx        <= '0;
    end else begin
      unique case (state)
        S_CLR: begin
          clr_idx <= clr_idx + 1'b1;
          if (clr_idx == '1) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            byte_r <= in_data.in_byte;
            last_r <= in_data.in_last;
            state  <= S_HASH;
          end
        end
        S_HASH: begin
          slot <= {cur_prefix[4:0], byte_r} ^ {1'b0, cur_prefix};
          if (have_prefix) begin
            state <= S_RD;
          end
        end
        S_RD: state <= S_DICT;
        S_DICT: state <= S_CMP;
        S_CMP: begin
          if (live && !key_eq) begin
            slot  <= slot + 1'b1;
            state <= S_RD;
          end
        end
        S_SEND: begin
          if (!out_full) begin
            oidx <= oidx + 2'd1;
            if (({1'b0, oidx} + 3'd1) == ocnt) begin
              state <= S_IDLE;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
      if (finish) begin
        obuf        <= nbuf;
        ocnt        <= ncnt;
        oidx        <= '0;
        state       <= (ncnt != '0) ? S_SEND : S_IDLE;
        if (last_r) begin
          have_prefix <= 1'b0;
          cur_prefix  <= '0;
          next_free   <= lzw_pkg::FirstFree;
          nib_pending <= 1'b0;
          pend_nib    <= '0;
        end else begin
          have_prefix <= 1'b1;
          cur_prefix  <= new_prefix;
          nib_pending <= n_np;
          pend_nib    <= n_pn;
          if (ins) begin
            next_free <= next_free + 1'b1;
          end
        end
      end
    end
  end

  a_cnt_max: assert property (@(posedge clk) disable iff (rst)
    finish |-> ncnt <= 3'd4) else $error("too many bytes for one item");
  a_free_bound: assert property (@(posedge clk) disable iff (rst)
    next_free >= lzw_pkg::FirstFree && next_free <= (CW+1)'(DICT_LIMIT))
    else $error("free code out of range");
  a_send_nonzero: assert property (@(posedge clk) disable iff (rst)
    state == S_SEND |-> ocnt != '0) else $error("send with no bytes");
  a_last_resets: assert property (@(posedge clk) disable iff (rst)
    finish && last_r |=> !have_prefix) else $error("stream end kept prefix");

endmodule
`default_nettype wire

[rtl/lzw_compressor_12bit_core.sv]
// Top level of the 12-bit LZW compressor.
// Bytes enter through a two-entry queue and packed code bytes leave through a
// four-entry queue, so both sides stall independently of the engine. After
// reset the engine zeroes its 8192-entry hash slot table before it takes the
// first byte; the input queue still accepts two bytes meanwhile. Each byte
// leaves the queue and is hashed, then, unless it opens a stream, goes through
// dictionary probes (slot memory read, dictionary memory read, compare);
// probes walk linearly through an 8192-slot hash table. The output bytes of a
// byte (up to four at stream end) leave one by one and wait while the output
// queue is full.
// No clearing is needed between streams: a slot only counts when its code is
// below the next free code and that code's record points back.
`default_nettype none
module lzw_compressor_12bit_core #(
  parameter int unsigned DICT_LIMIT = 4095
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  output logic                  full,
  input  wire lzw_pkg::lzw_in_t in_item,
  output logic                  empty,
  input  wire logic             pop,
  output lzw_pkg::lzw_out_t     out_item
);
  localparam int unsigned InW  = $bits(lzw_pkg::lzw_in_t);
  localparam int unsigned OutW = $bits(lzw_pkg::lzw_out_t);

  logic              q_empty;
  logic [InW-1:0]    q_rdata;
  logic              eng_pop;
  logic              eng_push;
  logic              o_full;
  lzw_pkg::lzw_out_t eng_out;
  logic [OutW-1:0]   o_rdata;

  lzw_fifo #(.WIDTH(InW), .DEPTH(2)) u_in_q (
    .clk(clk), .rst(rst), .push(push), .wdata(in_item), .full(full),
    .pop(eng_pop), .rdata(q_rdata), .empty(q_empty)
  );

  lzw_engine #(.DICT_LIMIT(DICT_LIMIT)) u_engine (
    .clk(clk), .rst(rst), .in_valid(!q_empty), .in_data(lzw_pkg::lzw_in_t'(q_rdata)),
    .in_pop(eng_pop), .out_full(o_full), .out_push(eng_push), .out_data(eng_out)
  );

  lzw_fifo #(.WIDTH(OutW), .DEPTH(4)) u_out_q (
    .clk(clk), .rst(rst), .push(eng_push), .wdata(eng_out), .full(o_full),
    .pop(pop), .rdata(o_rdata), .empty(empty)
  );

  assign out_item = lzw_pkg::lzw_out_t'(o_rdata);

endmodule
`default_nettype wire

[verif/lzw_compressor_12bit_core_tb.sv]
// Self-checking testbench for the 12-bit LZW compressor core.
`timescale 1ns / 1ps
module lzw_compressor_12bit_core_tb;

  // A small dictionary limit lets a short random stream fill the dictionary.
  localparam int unsigned DictLimit = 300;
  localparam int unsigned CycleLimit = 1500000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic push = 1'b0;
  logic full;
  lzw_pkg::lzw_in_t in_item = '0;
  logic empty;
  logic pop = 1'b0;
  lzw_pkg::lzw_out_t out_item;

  lzw_compressor_12bit_core #(.DICT_LIMIT(DictLimit)) dut (
    .clk(clk), .rst(rst), .push(push), .full(full), .in_item(in_item),
    .empty(empty), .pop(pop), .out_item(out_item)
  );

  // Predictor state.
  int unsigned pair_codes[bit [19:0]];
  bit have_prefix = 1'b0;
  bit [11:0] prefix_code = '0;
  int unsigned next_code = 256;
  bit nib_valid = 1'b0;
  bit [3:0] nib_hold = '0;

  lzw_pkg::lzw_in_t pending_bytes[$];
  lzw_pkg::lzw_out_t expected_bytes[$];
  int errors = 0;
  int unsigned cycles = 0;
  int unsigned in_wait = 0;
  int unsigned out_wait = 0;
  int unsigned accepted = 0;
  int unsigned total_items = 0;

  task automatic put_code(input bit [11:0] code);
    if (nib_valid) begin
      expected_bytes.push_back('{out_byte: {nib_hold, code[11:8]}, out_last: 1'b0});
      expected_bytes.push_back('{out_byte: code[7:0], out_last: 1'b0});
      nib_valid = 1'b0;
    end else begin
      expected_bytes.push_back('{out_byte: code[11:4], out_last: 1'b0});
      nib_hold = code[3:0];
      nib_valid = 1'b1;
    end
  endtask

  task automatic compress_byte(input lzw_pkg::lzw_in_t it);
    bit [19:0] key;
    lzw_pkg::lzw_out_t tail;
    if (!have_prefix) begin
      prefix_code = {4'h0, it.in_byte};
      have_prefix = 1'b1;
    end else begin
      key = {prefix_code, it.in_byte};
      if (pair_codes.exists(key)) begin
        prefix_code = pair_codes[key][11:0];
      end else begin
        put_code(prefix_code);
        if (next_code < DictLimit) begin
          pair_codes[key] = next_code;
          next_code++;
        end
        prefix_code = {4'h0, it.in_byte};
      end
    end
    if (it.in_last) begin
      put_code(prefix_code);
      if (nib_valid) expected_bytes.push_back('{out_byte: {nib_hold, 4'h0}, out_last: 1'b0});
      tail = expected_bytes.pop_back();
      tail.out_last = 1'b1;
      expected_bytes.push_back(tail);
      // A finished stream starts the next one from a fresh dictionary.
      pair_codes.delete();
      have_prefix = 1'b0;
      prefix_code = '0;
      next_code = 256;
      nib_valid = 1'b0;
      nib_hold = '0;
    end
  endtask

  // Mode 0: any byte, mode 1: a four-letter alphabet, mode 2: one repeated byte.
  task automatic add_stream(input int unsigned len, input int unsigned mode);
    lzw_pkg::lzw_in_t it;
    bit [7:0] base;
    base = 8'($urandom_range(0, 255));
    for (int unsigned i = 0; i < len; i++) begin
      case (mode)
        0: it.in_byte = 8'($urandom_range(0, 255));
        1: it.in_byte = base ^ 8'($urandom_range(0, 3));
        default: it.in_byte = base;
      endcase
      it.in_last = (i == len - 1);
      pending_bytes.push_back(it);
    end
  endtask

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("lzw_compressor_12bit_core_tb: done, errors");
      $finish;
    end
  end

  // Driver: one beat per pending byte, with a random gap after each beat.
  always @(posedge clk) begin
    if (rst) begin
      push <= 1'b0;
    end else begin
      if (push && !full) begin
        compress_byte(in_item);
        accepted++;
        in_wait = $urandom_range(0, 4);
      end
      if (!push || !full) begin
        if (in_wait == 0 && pending_bytes.size() > 0) begin
          in_item <= pending_bytes.pop_front();
          push <= 1'b1;
        end else begin
          push <= 1'b0;
          if (in_wait > 0) in_wait--;
        end
      end
    end
  end

  // Monitor: checks each result beat against the oldest expected byte.
  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (expected_bytes.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual byte %02h last %0b",
                   $time, out_item.out_byte, out_item.out_last);
          errors++;
        end else begin
          if (out_item.out_byte !== expected_bytes[0].out_byte) begin
            $display("%0t: out_byte mismatch, expected %02h, actual %02h",
                     $time, expected_bytes[0].out_byte, out_item.out_byte);
            errors++;
          end
          if (out_item.out_last !== expected_bytes[0].out_last) begin
            $display("%0t: out_last mismatch, expected %0b, actual %0b",
                     $time, expected_bytes[0].out_last, out_item.out_last);
            errors++;
          end
          void'(expected_bytes.pop_front());
        end
        out_wait = $urandom_range(0, 4);
      end
      if (out_wait == 0) begin
        pop <= 1'b1;
      end else begin
        pop <= 1'b0;
        out_wait--;
      end
    end
  end

  initial begin
    // Single-byte streams at both byte extremes, then short edge streams.
    pending_bytes.push_back('{in_byte: 8'h00, in_last: 1'b1});
    pending_bytes.push_back('{in_byte: 8'hFF, in_last: 1'b1});
    pending_bytes.push_back('{in_byte: 8'h00, in_last: 1'b0});
    pending_bytes.push_back('{in_byte: 8'hFF, in_last: 1'b1});
    add_stream(3, 0);
    add_stream(10, 2);
    add_stream(6, 1);
    // Enough distinct pairs to fill the dictionary and keep going past it.
    add_stream(300, 0);
    while (pending_bytes.size() < 450) begin
      add_stream($urandom_range(1, 30), $urandom_range(0, 2));
    end
    total_items = pending_bytes.size();
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    wait (accepted == total_items);
    wait (expected_bytes.size() == 0);
    repeat (50) @(posedge clk);
    if (errors == 0 && expected_bytes.size() == 0) begin
      $display("lzw_compressor_12bit_core_tb: done, clean");
    end else begin
      $display("lzw_compressor_12bit_core_tb: done, errors");
    end
    $finish;
  end

endmodule

[lzw_compressor_12bit_core.f]
rtl/lzw_pkg.sv
rtl/lzw_fifo.sv
rtl/lzw_engine.sv
rtl/lzw_compressor_12bit_core.sv
verif/lzw_compressor_12bit_core_tb.sv
